### rtl/core/msat_pkg.sv
// Package for the masked summed-area table unit.
// Holds the channel word types, shared widths, register codes and saturating adders.
// No dependencies.
package msat_pkg;

   localparam int VALUE_WIDTH    = 32;
   localparam int SUM_BITS       = 64;
   localparam int COUNT_BITS     = 25;
   localparam int SIZE_BITS      = 13;
   localparam int QUEUE_DEPTH    = 4;
   localparam int CSR_ADDR_BITS  = 3;
   localparam int CSR_DATA_BITS  = 32;

   localparam logic [COUNT_BITS-1:0] COUNT_MAX      = '1;
   localparam logic [SIZE_BITS-1:0]  GRID_DIM_RESET = 13'd4096;

   // Register index, taken from the word address of the configuration port.
   typedef enum logic {
      REG_GRID_DIM = 1'b0
   } csr_index_type;

   typedef struct packed {
      logic [VALUE_WIDTH-1:0] observed_value;
      logic [VALUE_WIDTH-1:0] expected_value;
      logic                   row_is_bad;
      logic                   col_is_bad;
   } req_type;

   typedef struct packed {
      logic [SUM_BITS-1:0]   observed_sum;
      logic [SUM_BITS-1:0]   expected_sum;
      logic [COUNT_BITS-1:0] good_count;
      logic                  end_of_row;
   } rsp_type;

   // Work handed from the front end to the back end for one cell.
   typedef struct packed {
      logic                  has_above;
      logic                  end_of_row;
      logic [SUM_BITS-1:0]   row_observed;
      logic [SUM_BITS-1:0]   row_expected;
      logic [COUNT_BITS-1:0] row_count;
   } row_sums_type;

   function automatic logic [SUM_BITS-1:0] sat_add_sum(input logic [SUM_BITS-1:0] a,
                                                       input logic [SUM_BITS-1:0] b);
      logic [SUM_BITS:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[SUM_BITS] ? {SUM_BITS{1'b1}} : s[SUM_BITS-1:0];
   endfunction

   function automatic logic [COUNT_BITS-1:0] sat_add_count(input logic [COUNT_BITS-1:0] a,
                                                           input logic [COUNT_BITS-1:0] b);
      logic [COUNT_BITS:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[COUNT_BITS] ? COUNT_MAX : s[COUNT_BITS-1:0];
   endfunction

endpackage

### rtl/core/masked_summed_area_table_unit.sv
// Masked summed-area table unit: streams a square matrix in raster order and
// returns the observed, expected and count summed-area tables. Uses msat_pkg,
// msat_front, msat_queue and msat_back.
//
// Usage:
//   req channel: one matrix cell per word, row after row. rsp channel: one
//   result word per cell, in the same order, end_of_row set on the last column.
//   Both channels move a word when valid is high and stall is low.
//   The csr port holds the grid dimension at byte address 0; writing it restarts
//   the stream at cell (0,0). Write it only while no cell is in flight.
// Path: an accepted cell is written into the queue, popped into the second stage
//   with its line memory read, then held in the result register.
// Throughput: one cell per cycle unless stalled; the front end's running row sum is one
//   saturating add per cycle; the line memory takes one read and one write per cycle.
// Stall: a receiver stall holds the result register and then fills the
//   four-word queue; req_stall rises only when that queue is full.
// Reset: the stream restarts at cell (0,0), the grid dimension returns to 4096 and
//   all words in flight are dropped. The line memory needs no clearing since row 0
//   never uses what it reads.
module masked_summed_area_table_unit #(
   parameter int MAX_SIZE = 4096
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  msat_pkg::req_type                  req_data,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output msat_pkg::rsp_type                  rsp_data,
   input  logic                               csr_psel,
   input  logic                               csr_penable,
   input  logic                               csr_pwrite,
   input  logic [msat_pkg::CSR_ADDR_BITS-1:0] csr_paddr,
   input  logic [msat_pkg::CSR_DATA_BITS-1:0] csr_pwdata,
   output logic [msat_pkg::CSR_DATA_BITS-1:0] csr_prdata,
   output logic                               csr_pready
);

   localparam int IdxBits   = $clog2(MAX_SIZE);
   localparam int SizeBits  = $clog2(MAX_SIZE + 1);
   localparam int QWidth    = IdxBits + $bits(msat_pkg::row_sums_type);
   localparam int LevelBits = $clog2(msat_pkg::QUEUE_DEPTH + 1);
   localparam int ResetSize = (4096 > MAX_SIZE) ? MAX_SIZE : 4096;

   logic [msat_pkg::SIZE_BITS-1:0] size_ff, size_in;
   logic [SizeBits-1:0]            eff_size_ff, eff_size_in;

   msat_pkg::csr_index_type        csr_index;
   logic                           csr_write;
   logic                           restart;
   logic [msat_pkg::SIZE_BITS-1:0] size_wr;

   logic                           push;
   logic [IdxBits-1:0]             push_col;
   msat_pkg::row_sums_type         push_sums;
   logic                           q_pop;
   logic                           q_full;
   logic                           q_empty;
   logic [LevelBits-1:0]           q_level;
   logic [QWidth-1:0]              q_data;
   logic [IdxBits-1:0]             q_col;
   msat_pkg::row_sums_type         q_sums;

   assign csr_pready = 1'b1;
   assign csr_index  = msat_pkg::csr_index_type'(csr_paddr[2]);
   assign csr_write  = csr_psel && csr_penable && csr_pwrite;
   assign size_wr    = csr_pwdata[msat_pkg::SIZE_BITS-1:0];

   always_comb begin
      restart     = 1'b0;
      size_in     = size_ff;
      eff_size_in = eff_size_ff;
      csr_prdata  = '0;
      unique case (csr_index)
         msat_pkg::REG_GRID_DIM: begin
            csr_prdata = msat_pkg::CSR_DATA_BITS'(size_ff);
            if (csr_write) begin
               restart = 1'b1;
               size_in = size_wr;
               // A size of zero acts as one; sizes beyond the line memory clamp.
               if (size_wr == '0) begin
                  eff_size_in = SizeBits'(1);
               end else if (32'(size_wr) > 32'(MAX_SIZE)) begin
                  eff_size_in = SizeBits'(MAX_SIZE);
               end else begin
                  eff_size_in = SizeBits'(size_wr);
               end
            end
         end
         default: begin
            csr_prdata = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         size_ff     <= msat_pkg::GRID_DIM_RESET;
         eff_size_ff <= SizeBits'(ResetSize);
      end else begin
         size_ff     <= size_in;
         eff_size_ff <= eff_size_in;
      end
   end

   assign req_stall = q_full;

   msat_front #(
      .MAX_SIZE (MAX_SIZE)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .restart   (restart),
      .size      (eff_size_ff),
      .req_valid (req_valid),
      .req_data  (req_data),
      .q_full    (q_full),
      .push      (push),
      .push_col  (push_col),
      .push_sums (push_sums)
   );

   msat_queue #(
      .WIDTH (QWidth),
      .DEPTH (msat_pkg::QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data ({push_col, push_sums}),
      .pop       (q_pop),
      .pop_data  (q_data),
      .full      (q_full),
      .empty     (q_empty),
      .level     (q_level)
   );

   assign {q_col, q_sums} = q_data;

   msat_back #(
      .MAX_SIZE (MAX_SIZE)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .q_empty   (q_empty),
      .q_col     (q_col),
      .q_sums    (q_sums),
      .q_pop     (q_pop),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

`ifndef SYNTHESIS
   a_accept_lands : assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> !q_empty)
      else $error("accepted word did not reach the queue");

   a_level_bound : assert property (@(posedge clock) disable iff (reset)
      q_level <= LevelBits'(msat_pkg::QUEUE_DEPTH))
      else $error("queue level beyond its depth");

   a_pop_nonempty : assert property (@(posedge clock) disable iff (reset)
      q_pop |-> !q_empty)
      else $error("back end popped an empty queue");

   a_full_level : assert property (@(posedge clock) disable iff (reset)
      (q_level == LevelBits'(msat_pkg::QUEUE_DEPTH)) |-> !(q_pop && q_empty))
      else $error("queue full and empty flags disagree");
`endif

endmodule

### rtl/core/msat_ram.sv
// Generic single-port-write, single-port-read RAM with a registered read.
// No dependencies.
module msat_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### rtl/core/msat_front.sv
// Front end of the masked summed-area table unit: tracks the cell position,
// decides whether a cell counts and keeps the running row sums. Uses msat_pkg.
module msat_front #(
   parameter int MAX_SIZE = 4096
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           restart,
   input  logic [$clog2(MAX_SIZE+1)-1:0]  size,
   input  logic                           req_valid,
   input  msat_pkg::req_type              req_data,
   input  logic                           q_full,
   output logic                           push,
   output logic [$clog2(MAX_SIZE)-1:0]    push_col,
   output msat_pkg::row_sums_type         push_sums
);

   localparam int IdxBits  = $clog2(MAX_SIZE);
   localparam int SizeBits = $clog2(MAX_SIZE + 1);

   logic [IdxBits-1:0]              col_ff, col_in;
   logic [IdxBits-1:0]              row_ff, row_in;
   logic [msat_pkg::SUM_BITS-1:0]   obs_acc_ff, obs_acc_in;
   logic [msat_pkg::SUM_BITS-1:0]   exp_acc_ff, exp_acc_in;
   logic [msat_pkg::COUNT_BITS-1:0] cnt_acc_ff, cnt_acc_in;

   logic                            counted;
   logic                            last_col;
   logic                            last_row;
   logic [msat_pkg::SUM_BITS-1:0]   obs_new;
   logic [msat_pkg::SUM_BITS-1:0]   exp_new;
   logic [msat_pkg::COUNT_BITS-1:0] cnt_new;

   assign push = req_valid && !q_full;

   always_comb begin
      // Only cells strictly above the diagonal with good row and column count.
      counted  = (col_ff > row_ff) && !req_data.row_is_bad && !req_data.col_is_bad;
      last_col = (SizeBits'(col_ff) + SizeBits'(1)) == size;
      last_row = (SizeBits'(row_ff) + SizeBits'(1)) == size;

      obs_new = obs_acc_ff;
      exp_new = exp_acc_ff;
      cnt_new = cnt_acc_ff;
      if (counted) begin
         obs_new = msat_pkg::sat_add_sum(obs_acc_ff,
                                         msat_pkg::SUM_BITS'(req_data.observed_value));
         exp_new = msat_pkg::sat_add_sum(exp_acc_ff,
                                         msat_pkg::SUM_BITS'(req_data.expected_value));
         cnt_new = msat_pkg::sat_add_count(cnt_acc_ff, msat_pkg::COUNT_BITS'(1));
      end

      push_col               = col_ff;
      push_sums.has_above    = (row_ff != '0);
      push_sums.end_of_row   = last_col;
      push_sums.row_observed = obs_new;
      push_sums.row_expected = exp_new;
      push_sums.row_count    = cnt_new;

      col_in     = col_ff;
      row_in     = row_ff;
      obs_acc_in = obs_acc_ff;
      exp_acc_in = exp_acc_ff;
      cnt_acc_in = cnt_acc_ff;
      if (restart) begin
         col_in     = '0;
         row_in     = '0;
         obs_acc_in = '0;
         exp_acc_in = '0;
         cnt_acc_in = '0;
      end else if (push) begin
         if (last_col) begin
            col_in     = '0;
            row_in     = last_row ? '0 : row_ff + IdxBits'(1);
            obs_acc_in = '0;
            exp_acc_in = '0;
            cnt_acc_in = '0;
         end else begin
            col_in     = col_ff + IdxBits'(1);
            obs_acc_in = obs_new;
            exp_acc_in = exp_new;
            cnt_acc_in = cnt_new;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff     <= '0;
         row_ff     <= '0;
         obs_acc_ff <= '0;
         exp_acc_ff <= '0;
         cnt_acc_ff <= '0;
      end else begin
         col_ff     <= col_in;
         row_ff     <= row_in;
         obs_acc_ff <= obs_acc_in;
         exp_acc_ff <= exp_acc_in;
         cnt_acc_ff <= cnt_acc_in;
      end
   end

endmodule

### rtl/core/msat_queue.sv
// Short flip-flop FIFO between the front and back ends.
// No dependencies.
module msat_queue #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       push,
   input  logic [WIDTH-1:0]           push_data,
   input  logic                       pop,
   output logic [WIDTH-1:0]           pop_data,
   output logic                       full,
   output logic                       empty,
   output logic [$clog2(DEPTH+1)-1:0] level
);

   localparam int PtrBits   = $clog2(DEPTH);
   localparam int LevelBits = $clog2(DEPTH + 1);

   logic [WIDTH-1:0]     slot_ff [DEPTH];
   logic [PtrBits-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PtrBits-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [LevelBits-1:0] level_ff, level_in;

   assign full     = (level_ff == LevelBits'(DEPTH));
   assign empty    = (level_ff == '0);
   assign level    = level_ff;
   assign pop_data = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      level_in  = level_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PtrBits'(DEPTH - 1)) ? '0 : wr_ptr_ff + PtrBits'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PtrBits'(DEPTH - 1)) ? '0 : rd_ptr_ff + PtrBits'(1);
      end
      if (push && !pop) begin
         level_in = level_ff + LevelBits'(1);
      end else if (pop && !push) begin
         level_in = level_ff - LevelBits'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         level_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         level_ff  <= level_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

### rtl/core/msat_back.sv
// Back end of the masked summed-area table unit: reads the previous row's
// results, adds the row sums, writes the line memory and drives the result word.
// Uses msat_pkg and msat_ram.
module msat_back #(
   parameter int MAX_SIZE = 4096
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         q_empty,
   input  logic [$clog2(MAX_SIZE)-1:0]  q_col,
   input  msat_pkg::row_sums_type       q_sums,
   output logic                         q_pop,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output msat_pkg::rsp_type            rsp_data
);

   localparam int IdxBits  = $clog2(MAX_SIZE);
   localparam int RamWidth = 2 * msat_pkg::SUM_BITS + msat_pkg::COUNT_BITS;

   logic                            s2_valid_ff, s2_valid_in;
   logic [IdxBits-1:0]              s2_col_ff;
   msat_pkg::row_sums_type          s2_sums_ff;
   logic                            rsp_valid_ff, rsp_valid_in;
   msat_pkg::rsp_type               rsp_data_ff;

   logic                            out_ready;
   logic                            s2_advance;
   logic [RamWidth-1:0]             ram_rd_data;
   logic [RamWidth-1:0]             ram_wr_data;
   logic [msat_pkg::SUM_BITS-1:0]   up_obs;
   logic [msat_pkg::SUM_BITS-1:0]   up_exp;
   logic [msat_pkg::COUNT_BITS-1:0] up_cnt;
   msat_pkg::rsp_type               result;

   // The line memory is read when an entry leaves the queue; its registered
   // data holds while the entry waits in the second stage.
   msat_ram #(
      .WIDTH (RamWidth),
      .DEPTH (MAX_SIZE)
   ) u_line_ram (
      .clock   (clock),
      .wr_en   (s2_advance),
      .wr_addr (s2_col_ff),
      .wr_data (ram_wr_data),
      .rd_en   (q_pop),
      .rd_addr (q_col),
      .rd_data (ram_rd_data)
   );

   always_comb begin
      out_ready  = !rsp_valid_ff || !rsp_stall;
      s2_advance = s2_valid_ff && out_ready;
      q_pop      = !q_empty && (!s2_valid_ff || s2_advance);

      // Row 0 sees zeros above.
      up_obs = '0;
      up_exp = '0;
      up_cnt = '0;
      if (s2_sums_ff.has_above) begin
         {up_obs, up_exp, up_cnt} = ram_rd_data;
      end

      result.observed_sum = msat_pkg::sat_add_sum(up_obs, s2_sums_ff.row_observed);
      result.expected_sum = msat_pkg::sat_add_sum(up_exp, s2_sums_ff.row_expected);
      result.good_count   = msat_pkg::sat_add_count(up_cnt, s2_sums_ff.row_count);
      result.end_of_row   = s2_sums_ff.end_of_row;
      ram_wr_data = {result.observed_sum, result.expected_sum, result.good_count};

      s2_valid_in = s2_valid_ff;
      if (q_pop) begin
         s2_valid_in = 1'b1;
      end else if (s2_advance) begin
         s2_valid_in = 1'b0;
      end

      rsp_valid_in = rsp_valid_ff;
      if (s2_advance) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s2_valid_ff  <= s2_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (q_pop) begin
         s2_col_ff  <= q_col;
         s2_sums_ff <= q_sums;
      end
      if (s2_advance) begin
         rsp_data_ff <= result;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

### bench/tb_masked_summed_area_table_unit.sv
// Self-checking bench for masked_summed_area_table_unit: streams matrices of many sizes,
// predicts every summed-area word in step with the stream and compares field by field.
// Depends on msat_pkg and the unit's RTL only.
module tb_masked_summed_area_table_unit;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int LINE_DEPTH    = 4096;
   localparam int PIPE_LATENCY  = 3;
   localparam int RANDOM_CELLS  = 820;
   localparam int WIDE_CELLS    = 300;
   localparam int CYCLE_LIMIT   = 400000;
   localparam int REPORT_LIMIT  = 100;
   localparam int IDLE_PERCENT  = 34;
   localparam int HOLD_CYCLES   = 300;
   localparam int CALM_FIRST    = 1500;
   localparam int CALM_LAST     = 2500;
   localparam int ABOVE_BITS    = msat_pkg::CSR_DATA_BITS - msat_pkg::SIZE_BITS;

   localparam logic [msat_pkg::CSR_ADDR_BITS-1:0] SIZE_REG_ADDR  =
      msat_pkg::CSR_ADDR_BITS'(4 * int'(msat_pkg::REG_GRID_DIM));
   // One word past the last register; writes there must be ignored.
   localparam logic [msat_pkg::CSR_ADDR_BITS-1:0] SPARE_REG_ADDR =
      msat_pkg::CSR_ADDR_BITS'(4 * (int'(msat_pkg::REG_GRID_DIM) + 1));
   localparam logic [msat_pkg::VALUE_WIDTH-1:0]   ALL_ONES       = '1;

   logic                               clock = 1'b0;
   logic                               reset = 1'b1;
   logic                               req_valid = 1'b0;
   logic                               req_stall;
   msat_pkg::req_type                  req_data = '0;
   logic                               rsp_valid;
   logic                               rsp_stall = 1'b0;
   msat_pkg::rsp_type                  rsp_data;
   logic                               csr_psel = 1'b0;
   logic                               csr_penable = 1'b0;
   logic                               csr_pwrite = 1'b0;
   logic [msat_pkg::CSR_ADDR_BITS-1:0] csr_paddr = '0;
   logic [msat_pkg::CSR_DATA_BITS-1:0] csr_pwdata = '0;
   logic [msat_pkg::CSR_DATA_BITS-1:0] csr_prdata;
   logic                               csr_pready;

   masked_summed_area_table_unit #(
      .MAX_SIZE(LINE_DEPTH)
   ) u_dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_data(req_data),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_data(rsp_data),
      .csr_psel(csr_psel),
      .csr_penable(csr_penable),
      .csr_pwrite(csr_pwrite),
      .csr_paddr(csr_paddr),
      .csr_pwdata(csr_pwdata),
      .csr_prdata(csr_prdata),
      .csr_pready(csr_pready)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   msat_pkg::req_type cells_to_send[$];
   msat_pkg::rsp_type table_entries_due[$];
   msat_pkg::rsp_type due_entry;
   logic              req_taken = 1'b0;
   int unsigned       accepted_cells = 0;
   int unsigned       failures = 0;
   int unsigned       cycle_count = 0;
   int unsigned       hold_left = 0;
   logic              hold_done = 1'b0;
   logic              calm;

   assign calm = (cycle_count >= CALM_FIRST) && (cycle_count < CALM_LAST);

   // Shadow of the unit's state.
   logic [msat_pkg::SIZE_BITS-1:0]  size_setting = msat_pkg::GRID_DIM_RESET;
   int unsigned                     cur_col = 0;
   int unsigned                     cur_row = 0;
   logic [msat_pkg::SUM_BITS-1:0]   run_observed = '0;
   logic [msat_pkg::SUM_BITS-1:0]   run_expected = '0;
   logic [msat_pkg::COUNT_BITS-1:0] run_count = '0;
   logic [msat_pkg::SUM_BITS-1:0]   line_observed [LINE_DEPTH];
   logic [msat_pkg::SUM_BITS-1:0]   line_expected [LINE_DEPTH];
   logic [msat_pkg::COUNT_BITS-1:0] line_count [LINE_DEPTH];

   function automatic int unsigned active_size(input logic [msat_pkg::SIZE_BITS-1:0] setting);
      if (setting == '0) return 1;
      if (setting > LINE_DEPTH) return LINE_DEPTH;
      return setting;
   endfunction

   function automatic logic [msat_pkg::SUM_BITS-1:0] clamp_sum(
      input logic [msat_pkg::SUM_BITS-1:0] a,
      input logic [msat_pkg::SUM_BITS-1:0] b);
      logic [msat_pkg::SUM_BITS-1:0] s;
      s = a + b;
      return (s < a) ? '1 : s;
   endfunction

   function automatic logic [msat_pkg::COUNT_BITS-1:0] clamp_count(
      input logic [msat_pkg::COUNT_BITS-1:0] a,
      input logic [msat_pkg::COUNT_BITS-1:0] b);
      int unsigned s;
      s = 32'(a) + 32'(b);
      return (s > 32'(msat_pkg::COUNT_MAX)) ? msat_pkg::COUNT_MAX
                                            : msat_pkg::COUNT_BITS'(s);
   endfunction

   function automatic void rewind_stream();
      cur_col = 0;
      cur_row = 0;
      run_observed = '0;
      run_expected = '0;
      run_count = '0;
   endfunction

   // Folds one cell into the row sums and returns the table word it produces.
   function automatic msat_pkg::rsp_type integrate_cell(input msat_pkg::req_type word_in);
      msat_pkg::rsp_type entry;
      int unsigned       n;
      n = active_size(size_setting);
      if (cur_col >= n || cur_row >= n) rewind_stream();
      if (cur_col > cur_row && !word_in.row_is_bad && !word_in.col_is_bad) begin
         run_observed = clamp_sum(run_observed,
                                  msat_pkg::SUM_BITS'(word_in.observed_value));
         run_expected = clamp_sum(run_expected,
                                  msat_pkg::SUM_BITS'(word_in.expected_value));
         run_count = clamp_count(run_count, msat_pkg::COUNT_BITS'(1));
      end
      entry.observed_sum = clamp_sum((cur_row > 0) ? line_observed[cur_col] : '0, run_observed);
      entry.expected_sum = clamp_sum((cur_row > 0) ? line_expected[cur_col] : '0, run_expected);
      entry.good_count = clamp_count((cur_row > 0) ? line_count[cur_col] : '0, run_count);
      entry.end_of_row = (cur_col + 1 == n);
      line_observed[cur_col] = entry.observed_sum;
      line_expected[cur_col] = entry.expected_sum;
      line_count[cur_col] = entry.good_count;
      if (entry.end_of_row) begin
         cur_col = 0;
         run_observed = '0;
         run_expected = '0;
         run_count = '0;
         cur_row = (cur_row + 1 == n) ? 0 : cur_row + 1;
      end else begin
         cur_col = cur_col + 1;
      end
      return entry;
   endfunction

   task automatic flag_failure(input string msg);
      failures++;
      if (failures <= REPORT_LIMIT) $display("%0t: %s", $time, msg);
   endtask

   // Monitor: predicts on every accepted cell and checks every accepted word.
   always @(posedge clock) begin
      req_taken <= !reset && req_valid && !req_stall;
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            if (table_entries_due.size() == 0) begin
               flag_failure($sformatf("result word %h arrived with none due", rsp_data));
            end else begin
               due_entry = table_entries_due.pop_front();
               if (rsp_data.observed_sum !== due_entry.observed_sum)
                  flag_failure($sformatf("observed_sum expected %h, got %h",
                                         due_entry.observed_sum, rsp_data.observed_sum));
               if (rsp_data.expected_sum !== due_entry.expected_sum)
                  flag_failure($sformatf("expected_sum expected %h, got %h",
                                         due_entry.expected_sum, rsp_data.expected_sum));
               if (rsp_data.good_count !== due_entry.good_count)
                  flag_failure($sformatf("good_count expected %h, got %h",
                                         due_entry.good_count, rsp_data.good_count));
               if (rsp_data.end_of_row !== due_entry.end_of_row)
                  flag_failure($sformatf("end_of_row expected %b, got %b",
                                         due_entry.end_of_row, rsp_data.end_of_row));
            end
         end
         if (req_valid && !req_stall) begin
            table_entries_due.push_back(integrate_cell(req_data));
            accepted_cells <= accepted_cells + 1;
         end
      end
   end

   // Driver: a presented word stays put until it is taken.
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_taken) void'(cells_to_send.pop_front());
         if (req_valid && !req_taken) begin
            // Still waiting for the current word to be taken.
         end else if (cells_to_send.size() != 0
                      && (calm || $urandom_range(0, 99) >= IDLE_PERCENT)) begin
            req_valid <= 1'b1;
            req_data <= cells_to_send[0];
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // Receiver: random stalls, plus one long hold-off while the sender keeps offering.
   always @(negedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else if (hold_left != 0) begin
         rsp_stall <= 1'b1;
         hold_left <= hold_left - 1;
      end else if (!hold_done && accepted_cells >= 200 && cells_to_send.size() >= 40) begin
         hold_done <= 1'b1;
         hold_left <= HOLD_CYCLES;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= !calm && ($urandom_range(0, 99) < IDLE_PERCENT);
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("Regression FAIL");
         $finish;
      end
   end

   task automatic csr_access(input logic is_write,
                             input logic [msat_pkg::CSR_ADDR_BITS-1:0] addr,
                             input logic [msat_pkg::CSR_DATA_BITS-1:0] wdata,
                             output logic [msat_pkg::CSR_DATA_BITS-1:0] rdata);
      @(negedge clock);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= is_write;
      csr_paddr <= addr;
      csr_pwdata <= wdata;
      @(negedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      rdata = csr_prdata;
      @(negedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      @(posedge clock);
   endtask

   task automatic check_size_readback();
      logic [msat_pkg::CSR_DATA_BITS-1:0] readback;
      csr_access(1'b0, SIZE_REG_ADDR, '0, readback);
      if (readback !== msat_pkg::CSR_DATA_BITS'(size_setting))
         flag_failure($sformatf("grid dimension read expected %h, got %h",
                                msat_pkg::CSR_DATA_BITS'(size_setting), readback));
   endtask

   // Waits until every cell is taken and every word has come back, then lets the
   // pipeline run dry.
   task automatic settle();
      while (cells_to_send.size() != 0 || table_entries_due.size() != 0) @(posedge clock);
      repeat (PIPE_LATENCY + 2) @(posedge clock);
   endtask

   task automatic set_register(input logic [msat_pkg::CSR_ADDR_BITS-1:0] addr,
                               input logic [msat_pkg::CSR_DATA_BITS-1:0] wdata);
      logic [msat_pkg::CSR_DATA_BITS-1:0] unused;
      settle();
      csr_access(1'b1, addr, wdata, unused);
      if (addr == SIZE_REG_ADDR) begin
         size_setting = wdata[msat_pkg::SIZE_BITS-1:0];
         rewind_stream();
      end
      check_size_readback();
   endtask

   task automatic push_cell(input logic [msat_pkg::VALUE_WIDTH-1:0] observed,
                            input logic [msat_pkg::VALUE_WIDTH-1:0] expected,
                            input logic row_bad, input logic col_bad);
      msat_pkg::req_type item;
      item.observed_value = observed;
      item.expected_value = expected;
      item.row_is_bad = row_bad;
      item.col_is_bad = col_bad;
      cells_to_send.push_back(item);
   endtask

   function automatic logic [msat_pkg::VALUE_WIDTH-1:0] draw_value();
      case ($urandom_range(0, 7))
         0: return '0;
         1: return ALL_ONES;
         default: return msat_pkg::VALUE_WIDTH'($urandom);
      endcase
   endfunction

   // Queues cells in raster order from (0,0). Well-formed streams keep the same bad mark along
   // each row and each column, as a real matrix does; the rest carry random marks.
   task automatic queue_cells(input int unsigned span, input int unsigned count,
                              input logic well_formed);
      logic        row_marks [LINE_DEPTH];
      logic        col_marks [LINE_DEPTH];
      int unsigned r;
      int unsigned c;
      int unsigned k;
      for (k = 0; k < span; k++) begin
         row_marks[k] = ($urandom_range(0, 4) == 0);
         col_marks[k] = ($urandom_range(0, 4) == 0);
      end
      r = 0;
      c = 0;
      for (k = 0; k < count; k++) begin
         if (well_formed)
            push_cell(draw_value(), draw_value(), row_marks[r], col_marks[c]);
         else
            push_cell(draw_value(), draw_value(), $urandom_range(0, 1), $urandom_range(0, 1));
         if (c + 1 == span) begin
            c = 0;
            r = (r + 1 == span) ? 0 : r + 1;
         end else begin
            c = c + 1;
         end
      end
   endtask

   initial begin
      int unsigned                    random_cells;
      int unsigned                    pick;
      int unsigned                    span;
      int unsigned                    count;
      logic [msat_pkg::SIZE_BITS-1:0] setting;

      random_cells = 0;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(posedge clock);
      check_size_readback();

      // Reset size, row 0: the diagonal cell, extreme values and every bad-mark pairing.
      push_cell(ALL_ONES, ALL_ONES, 1'b0, 1'b0);
      push_cell(ALL_ONES, '0, 1'b0, 1'b0);
      push_cell('0, ALL_ONES, 1'b0, 1'b0);
      push_cell(ALL_ONES, ALL_ONES, 1'b1, 1'b0);
      push_cell(ALL_ONES, ALL_ONES, 1'b0, 1'b1);
      push_cell(ALL_ONES, ALL_ONES, 1'b1, 1'b1);
      push_cell(ALL_ONES, ALL_ONES, 1'b0, 1'b0);

      // A size of zero behaves as one: every cell is a lone diagonal cell.
      set_register(SIZE_REG_ADDR, '0);
      repeat (3) push_cell(ALL_ONES, ALL_ONES, 1'b0, 1'b0);

      // Two whole 2x2 matrices, so the stream wraps back to (0,0).
      set_register(SIZE_REG_ADDR, msat_pkg::CSR_DATA_BITS'(2));
      for (int i = 0; i < 8; i++) push_cell(ALL_ONES, ALL_ONES, i == 6, 1'b0);

      // A write to an unused address must not restart the stream.
      set_register(SIZE_REG_ADDR, msat_pkg::CSR_DATA_BITS'(3));
      for (int i = 0; i < 5; i++) push_cell(ALL_ONES, msat_pkg::VALUE_WIDTH'(i), 1'b0, 1'b0);
      set_register(SPARE_REG_ADDR, msat_pkg::CSR_DATA_BITS'(1));
      for (int i = 0; i < 6; i++) push_cell(msat_pkg::VALUE_WIDTH'(i), ALL_ONES, 1'b0, i == 4);

      // Oversized setting acts as the full line: a long stretch of row 0 with no row end.
      set_register(SIZE_REG_ADDR, msat_pkg::CSR_DATA_BITS'((1 << msat_pkg::SIZE_BITS) - 1));
      queue_cells(LINE_DEPTH, WIDE_CELLS, 1'b1);

      while (random_cells < RANDOM_CELLS) begin
         pick = $urandom_range(0, 19);
         if (pick == 0)
            setting = '0;
         else if (pick == 1)
            setting = msat_pkg::SIZE_BITS'(1);
         else if (pick == 2)
            setting = $urandom_range(0, 1) ? msat_pkg::SIZE_BITS'(LINE_DEPTH)
                    : msat_pkg::SIZE_BITS'($urandom_range(LINE_DEPTH + 1,
                                                          (1 << msat_pkg::SIZE_BITS) - 1));
         else if (pick < 6)
            setting = msat_pkg::SIZE_BITS'($urandom_range(13, 24));
         else
            setting = msat_pkg::SIZE_BITS'($urandom_range(2, 12));
         span = active_size(setting);
         if (span > 24)
            count = $urandom_range(20, 80);
         else if (span > 12)
            count = span * span;
         else
            count = span * span * $urandom_range(1, 3)
                  + (($urandom_range(0, 2) == 0) ? $urandom_range(1, span * span) : 0);
         if (count > RANDOM_CELLS - random_cells)
            count = RANDOM_CELLS - random_cells;
         // Bits above the register's width are sometimes set and must be dropped.
         set_register(SIZE_REG_ADDR,
                      {($urandom_range(0, 1) != 0) ? ABOVE_BITS'($urandom)
                                                   : ABOVE_BITS'(0),
                       setting});
         queue_cells(span, count, $urandom_range(0, 4) != 0);
         random_cells += count;
      end

      settle();
      repeat (10) @(posedge clock);
      if (failures == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule
